// ===== hw/rtl/tsbm_pkg.sv =====
// Shared types, constants and cosine table for the three-servo bend mapper.
package tsbm_pkg;

	// Fraction bits of the cosine used in the product (8..16).
	localparam int COS_FRAC_BITS = 14;
	localparam int TAB_FRAC      = 14;
	localparam int COS_W         = COS_FRAC_BITS + 1;
	localparam int BEND_FRAC     = 10;
	localparam int BEND_ONE      = 1024;
	localparam int BEND_W        = 11;
	localparam int DEG_W         = 9;
	localparam int ANG_W         = 8;
	localparam int MB_W          = ANG_W + BEND_W;
	localparam int PROD_W        = MB_W + COS_W;
	localparam int SHIFT         = BEND_FRAC + COS_FRAC_BITS;

	localparam int DIR_W         = 11;
	localparam int FRAC_W        = 12;
	localparam int IN_W          = 24;
	localparam int OUT_W         = 24;
	localparam int CFG_IDX_W     = 2;

	localparam int PHASE_B       = 240;
	localparam int PHASE_C       = 120;

	localparam int Q_DEPTH       = 4;
	localparam int Q_AW          = $clog2(Q_DEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER    = 2'd0,
		REG_MAX_BEND  = 2'd1,
		REG_LIMIT     = 2'd2,
		REG_UNUSED    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [ANG_W-1:0] center_position;
		logic [ANG_W-1:0] max_bend_degrees;
		logic [ANG_W-1:0] angle_limit;
	} cfg_t;

	// Classified command: direction in 0..359, bend saturated to 0..1024.
	typedef struct packed {
		logic [DEG_W-1:0]  dir;
		logic [BEND_W-1:0] bend;
	} item_t;

	typedef struct packed {
		logic       neg;
		logic [6:0] idx;
	} quad_t;

	localparam logic [15:0] COS_Q14 [0:90] = '{
		16'd16384, 16'd16382, 16'd16374, 16'd16362, 16'd16344, 16'd16322, 16'd16294,
		16'd16262, 16'd16225, 16'd16182, 16'd16135, 16'd16083, 16'd16026, 16'd15964,
		16'd15897, 16'd15826, 16'd15749, 16'd15668, 16'd15582, 16'd15491, 16'd15396,
		16'd15296, 16'd15191, 16'd15082, 16'd14968, 16'd14849, 16'd14726, 16'd14598,
		16'd14466, 16'd14330, 16'd14189, 16'd14044, 16'd13894, 16'd13741, 16'd13583,
		16'd13421, 16'd13255, 16'd13085, 16'd12911, 16'd12733, 16'd12551, 16'd12365,
		16'd12176, 16'd11982, 16'd11786, 16'd11585, 16'd11381, 16'd11174, 16'd10963,
		16'd10749, 16'd10531, 16'd10311, 16'd10087, 16'd9860,  16'd9630,  16'd9397,
		16'd9162,  16'd8923,  16'd8682,  16'd8438,  16'd8192,  16'd7943,  16'd7692,
		16'd7438,  16'd7182,  16'd6924,  16'd6664,  16'd6402,  16'd6138,  16'd5872,
		16'd5604,  16'd5334,  16'd5063,  16'd4790,  16'd4516,  16'd4240,  16'd3964,
		16'd3686,  16'd3406,  16'd3126,  16'd2845,  16'd2563,  16'd2280,  16'd1997,
		16'd1713,  16'd1428,  16'd1143,  16'd857,   16'd572,   16'd286,   16'd0
	};

	// Cosine magnitude at COS_FRAC_BITS, rounded half up when narrowing.
	function automatic logic [COS_W-1:0] cos_mag(input logic [6:0] idx);
		logic [31:0] t;
		logic [31:0] m;
		t = {16'd0, COS_Q14[idx]};
		if (COS_FRAC_BITS >= TAB_FRAC) begin
			m = t << (COS_FRAC_BITS - TAB_FRAC);
		end else begin
			m = (t + (32'd1 << (TAB_FRAC - COS_FRAC_BITS - 1))) >> (TAB_FRAC - COS_FRAC_BITS);
		end
		return m[COS_W-1:0];
	endfunction

	// Fold a phase in 0..359 onto the 0..90 table with a sign.
	function automatic quad_t fold_phase(input logic [DEG_W-1:0] p);
		quad_t q;
		logic [DEG_W-1:0] t;
		q.neg = 1'b0;
		if (p <= DEG_W'(90)) begin
			t = p;
		end else if (p <= DEG_W'(180)) begin
			t = DEG_W'(180) - p;
			q.neg = 1'b1;
		end else if (p <= DEG_W'(270)) begin
			t = p - DEG_W'(180);
			q.neg = 1'b1;
		end else begin
			t = DEG_W'(360) - p;
		end
		q.idx = t[6:0];
		return q;
	endfunction

	// Add a fixed phase offset and wrap to 0..359.
	function automatic logic [DEG_W-1:0] phase_add(input logic [DEG_W-1:0] d,
		input logic [DEG_W-1:0] k);
		logic [DEG_W:0] s;
		s = {1'b0, d} + {1'b0, k};
		if (s >= (DEG_W+1)'(360)) begin
			s = s - (DEG_W+1)'(360);
		end
		return s[DEG_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/tsbm_front.sv =====
// Front end: wrap the direction to 0..359 and saturate the bend fraction.
module tsbm_front (
	input  logic signed [tsbm_pkg::DIR_W-1:0]  direction_deg,
	input  logic signed [tsbm_pkg::FRAC_W-1:0] bend_fraction,
	output tsbm_pkg::item_t                    item
);
	import tsbm_pkg::*;

	logic signed [DIR_W:0] dir_ext;
	logic [DIR_W-1:0]      dir_pos;
	logic [DIR_W-1:0]      dir_red;

	always_comb begin
		// Lift negatives by three turns; the range then sits in 0..1079.
		dir_ext = {direction_deg[DIR_W-1], direction_deg} + (DIR_W+1)'(1080);
		dir_pos = direction_deg[DIR_W-1] ? dir_ext[DIR_W-1:0] : direction_deg;
		if (dir_pos >= DIR_W'(720)) begin
			dir_red = dir_pos - DIR_W'(720);
		end else if (dir_pos >= DIR_W'(360)) begin
			dir_red = dir_pos - DIR_W'(360);
		end else begin
			dir_red = dir_pos;
		end
		item.dir = dir_red[DEG_W-1:0];

		if (bend_fraction[FRAC_W-1]) begin
			item.bend = '0;
		end else if (bend_fraction > FRAC_W'(BEND_ONE)) begin
			item.bend = BEND_W'(BEND_ONE);
		end else begin
			item.bend = bend_fraction[BEND_W-1:0];
		end
	end

endmodule

// ===== hw/rtl/tsbm_queue.sv =====
// Short register queue between the front end and the arithmetic back end.
module tsbm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tsbm_pkg::item_t push_item,
	output logic            not_full,
	input  logic            pop,
	output logic            not_empty,
	output tsbm_pkg::item_t head
);
	import tsbm_pkg::*;

	item_t           mem_q [0:Q_DEPTH-1];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign not_full  = (count_q != (Q_AW+1)'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && not_full) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && not_full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && not_empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push && not_full, pop && not_empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (Q_AW+1)'(Q_DEPTH))
		else $error("queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");

	a_count_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(push && not_full && pop && not_empty) |=> $stable(count_q))
		else $error("queue count moved on simultaneous push and pop");

endmodule

// ===== hw/rtl/tsbm_back.sv =====
// Back end: cosine lookup, two-step product, center offset and clip.
module tsbm_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tsbm_pkg::cfg_t             cfg,
	input  logic                       q_valid,
	input  tsbm_pkg::item_t            q_item,
	output logic                       q_pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [tsbm_pkg::OUT_W-1:0] m_tdata
);
	import tsbm_pkg::*;

	logic              en;
	quad_t             quad [0:2];
	logic [DEG_W-1:0]  phase [0:2];

	logic              v_s1;
	logic [MB_W-1:0]   mb_s1;
	logic [COS_W-1:0]  cmag_s1 [0:2];
	logic [2:0]        neg_s1;

	logic              v_s2;
	logic [PROD_W-1:0] prod_s2 [0:2];
	logic [2:0]        neg_s2;

	logic [ANG_W-1:0]  ang [0:2];

	// Advance the whole pipe whenever the output register is free.
	assign en    = !m_tvalid || m_tready;
	assign q_pop = en && q_valid;

	assign phase[0] = q_item.dir;
	assign phase[1] = phase_add(q_item.dir, DEG_W'(PHASE_B));
	assign phase[2] = phase_add(q_item.dir, DEG_W'(PHASE_C));

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			quad[i] = fold_phase(phase[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mb_s1 <= MB_W'(cfg.max_bend_degrees) * MB_W'(q_item.bend);
			for (int i = 0; i < 3; i++) begin
				cmag_s1[i] <= cos_mag(quad[i].idx);
				neg_s1[i]  <= quad[i].neg;
			end
			for (int i = 0; i < 3; i++) begin
				prod_s2[i] <= PROD_W'(mb_s1) * PROD_W'(cmag_s1[i]);
			end
			neg_s2 <= neg_s1;
		end
	end

	always_comb begin
		logic [ANG_W-1:0]   pmag;
		logic signed [9:0]  sum;
		for (int i = 0; i < 3; i++) begin
			pmag = prod_s2[i][SHIFT+ANG_W-1:SHIFT];
			if (neg_s2[i]) begin
				sum = $signed({2'b00, cfg.center_position}) - $signed({2'b00, pmag});
			end else begin
				sum = $signed({2'b00, cfg.center_position}) + $signed({2'b00, pmag});
			end
			if (sum < 0) begin
				ang[i] = '0;
			end else if (sum > $signed({2'b00, cfg.angle_limit})) begin
				ang[i] = cfg.angle_limit;
			end else begin
				ang[i] = sum[ANG_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {ang[2], ang[1], ang[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_s1     <= q_valid;
			v_s2     <= v_s1;
			m_tvalid <= v_s2;
		end
	end

	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[ANG_W-1:0] <= cfg.angle_limit)
			&& (m_tdata[2*ANG_W-1:ANG_W] <= cfg.angle_limit)
			&& (m_tdata[3*ANG_W-1:2*ANG_W] <= cfg.angle_limit))
		else $error("servo angle above limit");

	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !en) |=> v_s2)
		else $error("stage two item lost during stall");

	a_stall_nopop: assert property (@(posedge clk) disable iff (!arst_n)
		!en |-> !q_pop)
		else $error("queue popped while pipe stalled");

endmodule

// ===== hw/rtl/three_servo_bend_mapper_core.sv =====
// Top level of the three-servo bend mapper: config registers, front, queue, back.
//
// channel | beat fields (lowest bit first)                     | accepted when
// s_      | direction_deg[10:0], bend_fraction[22:11], pad[23] | s_tvalid & s_tready
// m_      | servo_a[7:0], servo_b[15:8], servo_c[23:16]        | m_tvalid & m_tready
// cfg_    | cfg_index (0 center, 1 max bend, 2 limit), cfg_data | cfg_valid & cfg_ready
//
// One command per cycle sustained while the output is not stalled; after its beat is
// taken, a result passes the queue write, the lookup/first-multiply stage and the second
// multiply stage before it reaches the output register.
// Reset clears the queue and pipe valid bits and loads center 90, max bend 60,
// limit 170. A stalled output freezes the back pipe; the four-entry queue keeps
// taking input beats until it fills. Config writes are always taken.
module three_servo_bend_mapper_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tsbm_pkg::IN_W-1:0]      s_tdata,   // direction_deg, bend_fraction, pad
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [tsbm_pkg::OUT_W-1:0]     m_tdata,   // servo_a, servo_b, servo_c angles
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tsbm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tsbm_pkg::ANG_W-1:0]     cfg_data
);
	import tsbm_pkg::*;

	cfg_t  cfg_q;
	item_t front_item;
	item_t q_head;
	logic  q_not_full;
	logic  q_not_empty;
	logic  q_pop;

	// Config writes are registered with no wait state; unknown indexes drop silently.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_position  <= ANG_W'(90);
			cfg_q.max_bend_degrees <= ANG_W'(60);
			cfg_q.angle_limit      <= ANG_W'(170);
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CENTER:   cfg_q.center_position  <= cfg_data;
				REG_MAX_BEND: cfg_q.max_bend_degrees <= cfg_data;
				REG_LIMIT:    cfg_q.angle_limit      <= cfg_data;
				default:      cfg_q                  <= cfg_q;
			endcase
		end
	end

	// Accept input while the queue has room.
	assign s_tready = q_not_full;

	tsbm_front u_front (
		.direction_deg (s_tdata[DIR_W-1:0]),
		.bend_fraction (s_tdata[DIR_W+FRAC_W-1:DIR_W]),
		.item          (front_item)
	);

	tsbm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid),
		.push_item (front_item),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	tsbm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_not_empty),
		.q_item   (q_head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
